/* hdl/gdc3_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gdc3_pkg;

    // Sample and grid geometry
    localparam int SAMPLE_BITS = 24;
    localparam int RES_BITS    = 7;
    localparam int MAX_RES     = 100;
    localparam int MAX_PLANE   = 16384;
    localparam int PLANE_AW    = $clog2(MAX_PLANE);
    localparam int MEM_AW      = PLANE_AW + 1;
    localparam int MEM_DEPTH   = 2 * MAX_PLANE;

    // Configuration port
    localparam int RECIP_W     = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    // Datapath widths
    localparam int DIFF_W     = SAMPLE_BITS + 1;
    localparam int PROD_W     = DIFF_W + RECIP_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 16;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO     = ~SAT_HI;

    // Reset values
    localparam logic [RES_BITS-1:0] RES_RESET   = RES_BITS'(10);
    localparam logic [RECIP_W-1:0]  RECIP_RESET = RECIP_W'(29491);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RES_X      = 3'd0,
        REG_RES_Y      = 3'd1,
        REG_RES_Z      = 3'd2,
        REG_INV_TWO_DX = 3'd3,
        REG_INV_TWO_DY = 3'd4,
        REG_INV_TWO_DZ = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] fz;
        logic signed [SAMPLE_BITS-1:0] fy;
        logic signed [SAMPLE_BITS-1:0] fx;
    } sample_t;

    typedef struct packed {
        logic [RES_BITS-1:0] pos_x;
        logic [RES_BITS-1:0] pos_y;
        logic [RES_BITS-1:0] pos_z;
        logic                last;
    } meta_t;

    // Keep low bits, then clamp into 2..MAX_RES
    function automatic logic [RES_BITS-1:0] clamp_res(input logic [CFG_DATA_W-1:0] v);
        logic [RES_BITS-1:0] r;
        r = v[RES_BITS-1:0];
        if (r < RES_BITS'(2))
            r = RES_BITS'(2);
        if (r > RES_BITS'(MAX_RES))
            r = RES_BITS'(MAX_RES);
        return r;
    endfunction

    // Floor shift of a biased sum, then saturation to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] q;
        logic signed [SAMPLE_BITS-1:0] r;
        q = acc >>> FRAC_SHIFT;
        if (q > SAT_HI)
            r = SAT_HI[SAMPLE_BITS-1:0];
        else if (q < SAT_LO)
            r = SAT_LO[SAMPLE_BITS-1:0];
        else
            r = q[SAMPLE_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/grid_divergence_curl_3d_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Streaming 3D divergence and curl. Feed field samples in raster order (x
// fastest, then y, then z) on the input channel, one transfer per clock; the
// block takes one sample every cycle as long as the result side keeps up.
// For each interior point (not on any face of the res_x * res_y * res_z grid)
// one result transfer carries the divergence and the three curl components,
// scaled by the programmed 1/(2*spacing) values, rounded to Q12.12 and
// saturated, plus the point's indices and a last flag on the final interior
// point. A result leaves after the transfer of the sample one plane above
// its centre, through the plane store read register, then the difference,
// multiply, sum and round stages. Border points give no result.
// Throughput is set by the plane store: each sample does one write and four
// reads, served by two copies of the store with two read ports each. Writing
// a resolution register restarts the grid at its first sample; registers may
// only be written while the block is idle.

module grid_divergence_curl_3d_core
    import gdc3_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // Configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,

    // Sample stream
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] field_x,
    input  wire logic signed [SAMPLE_BITS-1:0] field_y,
    input  wire logic signed [SAMPLE_BITS-1:0] field_z,

    // Result stream
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      divergence,
    output logic signed [SAMPLE_BITS-1:0]      curl_x,
    output logic signed [SAMPLE_BITS-1:0]      curl_y,
    output logic signed [SAMPLE_BITS-1:0]      curl_z,
    output logic [RES_BITS-1:0]                pos_x,
    output logic [RES_BITS-1:0]                pos_y,
    output logic [RES_BITS-1:0]                pos_z,
    output logic                               last
);

    //--------------------------------------------------------------------
    // Configuration registers
    //--------------------------------------------------------------------
    logic [RES_BITS-1:0] res_x_reg, res_y_reg, res_z_reg;
    logic [RECIP_W-1:0]  inv_two_dx_reg, inv_two_dy_reg, inv_two_dz_reg;
    logic                res_write;

    always_comb
    begin
        res_write = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_RES_X, REG_RES_Y, REG_RES_Z: res_write = 1'b1;
                default:                         res_write = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_x_reg      <= RES_RESET;
            res_y_reg      <= RES_RESET;
            res_z_reg      <= RES_RESET;
            inv_two_dx_reg <= RECIP_RESET;
            inv_two_dy_reg <= RECIP_RESET;
            inv_two_dz_reg <= RECIP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_RES_X:      res_x_reg      <= clamp_res(cfg_data);
                REG_RES_Y:      res_y_reg      <= clamp_res(cfg_data);
                REG_RES_Z:      res_z_reg      <= clamp_res(cfg_data);
                REG_INV_TWO_DX: inv_two_dx_reg <= cfg_data[RECIP_W-1:0];
                REG_INV_TWO_DY: inv_two_dy_reg <= cfg_data[RECIP_W-1:0];
                REG_INV_TWO_DZ: inv_two_dz_reg <= cfg_data[RECIP_W-1:0];
                default:        ; // unknown index: no effect
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Pipeline flow control. Each stage moves on when it is empty or the
    // stage after it moves, so bubbles (border points) are squeezed out
    // and input keeps flowing while a finished result waits at the port.
    //--------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    logic accept;

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign accept   = in_valid && in_ready;

    //--------------------------------------------------------------------
    // Raster position of the incoming sample. lin_reg is y*res_x + x
    // within the current plane, kept as a counter to avoid a multiply.
    //--------------------------------------------------------------------
    logic [RES_BITS-1:0] column_count_reg, column_count_next;
    logic [RES_BITS-1:0] row_count_reg, row_count_next;
    logic [RES_BITS-1:0] plane_count_reg, plane_count_next;
    logic [PLANE_AW-1:0] lin_reg, lin_next;
    logic                col_end, row_end, plane_end;

    assign col_end   = (column_count_reg == res_x_reg - RES_BITS'(1));
    assign row_end   = (row_count_reg == res_y_reg - RES_BITS'(1));
    assign plane_end = (plane_count_reg == res_z_reg - RES_BITS'(1));

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        plane_count_next  = plane_count_reg;
        lin_next          = lin_reg;
        if (res_write)
        begin
            column_count_next = '0;
            row_count_next    = '0;
            plane_count_next  = '0;
            lin_next          = '0;
        end
        else if (accept)
        begin
            lin_next = lin_reg + PLANE_AW'(1);
            if (col_end)
            begin
                column_count_next = '0;
                if (row_end)
                begin
                    row_count_next = '0;
                    lin_next       = '0;
                    if (plane_end)
                        plane_count_next = '0;
                    else
                        plane_count_next = plane_count_reg + RES_BITS'(1);
                end
                else
                begin
                    row_count_next = row_count_reg + RES_BITS'(1);
                end
            end
            else
            begin
                column_count_next = column_count_reg + RES_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            plane_count_reg  <= '0;
            lin_reg          <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            plane_count_reg  <= plane_count_next;
            lin_reg          <= lin_next;
        end
    end

    // The incoming sample completes the operands of the point one plane
    // below it; that point is interior when it lies off every face.
    logic [RES_BITS:0] cx_p2, cy_p2, cz_p1;
    logic              interior;
    meta_t             meta_in;

    assign cx_p2 = {1'b0, column_count_reg} + (RES_BITS + 1)'(2);
    assign cy_p2 = {1'b0, row_count_reg} + (RES_BITS + 1)'(2);
    assign cz_p1 = {1'b0, plane_count_reg} + (RES_BITS + 1)'(1);

    assign interior = (plane_count_reg >= RES_BITS'(2))
                   && (column_count_reg != '0) && (cx_p2 <= {1'b0, res_x_reg})
                   && (row_count_reg != '0) && (cy_p2 <= {1'b0, res_y_reg});

    assign meta_in.pos_x = column_count_reg;
    assign meta_in.pos_y = row_count_reg;
    assign meta_in.pos_z = plane_count_reg - RES_BITS'(1);
    assign meta_in.last  = (cx_p2 == {1'b0, res_x_reg})
                        && (cy_p2 == {1'b0, res_y_reg})
                        && (cz_p1 == {1'b0, res_z_reg});

    //--------------------------------------------------------------------
    // Plane store: two banks picked by plane parity, so the bank being
    // written holds the plane two below and the other bank the plane just
    // below. Two copies, each one write and two reads per cycle:
    //   copy A: same point two planes down (read before overwrite), and
    //           the point one step on in the plane below (x+1 neighbour);
    //   copy B: the y-1 and y+1 neighbours in the plane below.
    // Reads and the write happen at the transfer edge, so every earlier
    // write is already in place and no forwarding is needed.
    //--------------------------------------------------------------------
    sample_t             mem_a [MEM_DEPTH];
    sample_t             mem_b [MEM_DEPTH];
    sample_t             sample_in;
    logic                bank_cur;
    logic [MEM_AW-1:0]   addr_here, addr_xp, addr_ym, addr_yp;
    logic [PLANE_AW-1:0] res_x_ext;

    assign sample_in.fx = field_x;
    assign sample_in.fy = field_y;
    assign sample_in.fz = field_z;

    assign bank_cur  = plane_count_reg[0];
    assign res_x_ext = PLANE_AW'(res_x_reg);
    assign addr_here = {bank_cur, lin_reg};
    assign addr_xp   = {~bank_cur, lin_reg + PLANE_AW'(1)};
    assign addr_ym   = {~bank_cur, lin_reg - res_x_ext};
    assign addr_yp   = {~bank_cur, lin_reg + res_x_ext};

    sample_t a_here_reg, a_xp_reg, b_ym_reg, b_yp_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_a[addr_here] <= sample_in;
            a_here_reg       <= mem_a[addr_here];
            a_xp_reg         <= mem_a[addr_xp];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_b[addr_here] <= sample_in;
            b_ym_reg         <= mem_b[addr_ym];
            b_yp_reg         <= mem_b[addr_yp];
        end
    end

    // The x-1 neighbour is the x+1 read made two samples earlier; rows are
    // contiguous in the linear address, so this holds across row ends too.
    sample_t xp_hist1_reg, xp_hist2_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xp_hist1_reg <= a_xp_reg;
            xp_hist2_reg <= xp_hist1_reg;
        end
    end

    //--------------------------------------------------------------------
    // Stage 1: sample and position alongside the store read data
    //--------------------------------------------------------------------
    sample_t nz_reg;
    meta_t   meta1_reg, meta2_reg, meta3_reg, meta4_reg, meta5_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nz_reg    <= sample_in;
            meta1_reg <= meta_in;
        end
    end

    //--------------------------------------------------------------------
    // Stage 2: central differences
    //--------------------------------------------------------------------
    logic signed [DIFF_W-1:0] dxfx_reg, dxfy_reg, dxfz_reg;
    logic signed [DIFF_W-1:0] dyfx_reg, dyfy_reg, dyfz_reg;
    logic signed [DIFF_W-1:0] dzfx_reg, dzfy_reg, dzfz_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            dxfx_reg  <= DIFF_W'(a_xp_reg.fx) - DIFF_W'(xp_hist2_reg.fx);
            dxfy_reg  <= DIFF_W'(a_xp_reg.fy) - DIFF_W'(xp_hist2_reg.fy);
            dxfz_reg  <= DIFF_W'(a_xp_reg.fz) - DIFF_W'(xp_hist2_reg.fz);
            dyfx_reg  <= DIFF_W'(b_yp_reg.fx) - DIFF_W'(b_ym_reg.fx);
            dyfy_reg  <= DIFF_W'(b_yp_reg.fy) - DIFF_W'(b_ym_reg.fy);
            dyfz_reg  <= DIFF_W'(b_yp_reg.fz) - DIFF_W'(b_ym_reg.fz);
            dzfx_reg  <= DIFF_W'(nz_reg.fx) - DIFF_W'(a_here_reg.fx);
            dzfy_reg  <= DIFF_W'(nz_reg.fy) - DIFF_W'(a_here_reg.fy);
            dzfz_reg  <= DIFF_W'(nz_reg.fz) - DIFF_W'(a_here_reg.fz);
            meta2_reg <= meta1_reg;
        end
    end

    //--------------------------------------------------------------------
    // Stage 3: scale by the reciprocals (exact Q.28 products)
    //--------------------------------------------------------------------
    logic signed [RECIP_W:0] kx, ky, kz;

    assign kx = $signed({1'b0, inv_two_dx_reg});
    assign ky = $signed({1'b0, inv_two_dy_reg});
    assign kz = $signed({1'b0, inv_two_dz_reg});

    logic signed [PROD_W-1:0] pxx_reg, pxy_reg, pxz_reg;
    logic signed [PROD_W-1:0] pyx_reg, pyy_reg, pyz_reg;
    logic signed [PROD_W-1:0] pzx_reg, pzy_reg, pzz_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            pxx_reg   <= dxfx_reg * kx;
            pxy_reg   <= dxfy_reg * kx;
            pxz_reg   <= dxfz_reg * kx;
            pyx_reg   <= dyfx_reg * ky;
            pyy_reg   <= dyfy_reg * ky;
            pyz_reg   <= dyfz_reg * ky;
            pzx_reg   <= dzfx_reg * kz;
            pzy_reg   <= dzfy_reg * kz;
            pzz_reg   <= dzfz_reg * kz;
            meta3_reg <= meta2_reg;
        end
    end

    //--------------------------------------------------------------------
    // Stage 4: exact sums plus the half-LSB rounding bias
    //--------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_div_reg, acc_cx_reg, acc_cy_reg, acc_cz_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            acc_div_reg <= ACC_W'(pxx_reg) + ACC_W'(pyy_reg) + ACC_W'(pzz_reg) + ROUND_BIAS;
            acc_cx_reg  <= ACC_W'(pyz_reg) - ACC_W'(pzy_reg) + ROUND_BIAS;
            acc_cy_reg  <= ACC_W'(pzx_reg) - ACC_W'(pxz_reg) + ROUND_BIAS;
            acc_cz_reg  <= ACC_W'(pxy_reg) - ACC_W'(pyx_reg) + ROUND_BIAS;
            meta4_reg   <= meta3_reg;
        end
    end

    //--------------------------------------------------------------------
    // Stage 5: floor to Q12.12, saturate; this is the output register
    //--------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] div_out_reg, cx_out_reg, cy_out_reg, cz_out_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            div_out_reg <= round_sat(acc_div_reg);
            cx_out_reg  <= round_sat(acc_cx_reg);
            cy_out_reg  <= round_sat(acc_cy_reg);
            cz_out_reg  <= round_sat(acc_cz_reg);
            meta5_reg   <= meta4_reg;
        end
    end

    //--------------------------------------------------------------------
    // Stage valid bits; only interior points enter as valid
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid && interior;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                v5_reg <= v4_reg;
        end
    end

    assign out_valid  = v5_reg;
    assign divergence = div_out_reg;
    assign curl_x     = cx_out_reg;
    assign curl_y     = cy_out_reg;
    assign curl_z     = cz_out_reg;
    assign pos_x      = meta5_reg.pos_x;
    assign pos_y      = meta5_reg.pos_y;
    assign pos_z      = meta5_reg.pos_z;
    assign last       = meta5_reg.last;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the streaming 3D divergence / curl stencil.
// Samples go in on the valid/ready input channel in raster order. Each
// accepted sample is run through a local stencil model, and any interior
// result it produces is queued. The result checker compares every output
// transfer, field by field, against the oldest queued entry.

module tb_top;
    import gdc3_pkg::*;

    // Register indexes that the block does not decode
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam int RES_AT_RESET   = 10;
    localparam int RECIP_AT_RESET = 29491;
    localparam int PROD_FRAC      = 16;        // Q.28 product down to Q12.12
    localparam int SETTLE_CYCLES  = 12;        // margin for the pipeline to drain
    localparam int REPORT_LIMIT   = 64;
    localparam int TIMEOUT_NS     = 4_000_000;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [RECIP_W-1:0]            RECIP_MAX  = '1;

    typedef enum int { MIX_FULL, MIX_SMALL, MIX_EXTREME, MIX_ANY } sample_mix_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] divergence;
        logic signed [SAMPLE_BITS-1:0] curl_x;
        logic signed [SAMPLE_BITS-1:0] curl_y;
        logic signed [SAMPLE_BITS-1:0] curl_z;
        logic [RES_BITS-1:0]           pos_x;
        logic [RES_BITS-1:0]           pos_y;
        logic [RES_BITS-1:0]           pos_z;
        logic                          last;
    } div_curl_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                          cfg_wr_en;
    logic [CFG_INDEX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;

    logic                          in_valid;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] field_x;
    logic signed [SAMPLE_BITS-1:0] field_y;
    logic signed [SAMPLE_BITS-1:0] field_z;

    logic                          out_valid;
    logic                          out_ready;
    logic signed [SAMPLE_BITS-1:0] divergence;
    logic signed [SAMPLE_BITS-1:0] curl_x;
    logic signed [SAMPLE_BITS-1:0] curl_y;
    logic signed [SAMPLE_BITS-1:0] curl_z;
    logic [RES_BITS-1:0]           pos_x;
    logic [RES_BITS-1:0]           pos_y;
    logic [RES_BITS-1:0]           pos_z;
    logic                          last;

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;

    // Stencil model state: grid shape, scale factors, raster position and the
    // two-bank plane store (bank = plane parity)
    int                            grid_nx, grid_ny, grid_nz;
    logic [RECIP_W-1:0]            recip_x, recip_y, recip_z;
    int                            col_at, row_at, plane_at;
    logic signed [SAMPLE_BITS-1:0] plane_fx [MEM_DEPTH];
    logic signed [SAMPLE_BITS-1:0] plane_fy [MEM_DEPTH];
    logic signed [SAMPLE_BITS-1:0] plane_fz [MEM_DEPTH];

    div_curl_t div_curl_expected [$];

    grid_divergence_curl_3d_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .field_x    (field_x),
        .field_y    (field_y),
        .field_z    (field_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .divergence (divergence),
        .curl_x     (curl_x),
        .curl_y     (curl_y),
        .curl_z     (curl_z),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .last       (last)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Stencil model
    // ------------------------------------------------------------------

    function automatic void reset_model();
        grid_nx  = RES_AT_RESET;
        grid_ny  = RES_AT_RESET;
        grid_nz  = RES_AT_RESET;
        recip_x  = RECIP_W'(RECIP_AT_RESET);
        recip_y  = RECIP_W'(RECIP_AT_RESET);
        recip_z  = RECIP_W'(RECIP_AT_RESET);
        col_at   = 0;
        row_at   = 0;
        plane_at = 0;
    endfunction

    // Resolution writes keep the low seven bits, clamp to 2..MAX_RES and
    // restart the raster; undecoded indexes change nothing.
    function automatic void apply_config(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0]  data);
        logic [RES_BITS-1:0] r;
        r = data[RES_BITS-1:0];
        if (r < 2)
            r = 2;
        if (r > MAX_RES)
            r = MAX_RES;
        case (idx)
            REG_RES_X:      grid_nx = r;
            REG_RES_Y:      grid_ny = r;
            REG_RES_Z:      grid_nz = r;
            REG_INV_TWO_DX: recip_x = data[RECIP_W-1:0];
            REG_INV_TWO_DY: recip_y = data[RECIP_W-1:0];
            REG_INV_TWO_DZ: recip_z = data[RECIP_W-1:0];
            default: ;
        endcase
        if (idx == REG_RES_X || idx == REG_RES_Y || idx == REG_RES_Z)
        begin
            col_at   = 0;
            row_at   = 0;
            plane_at = 0;
        end
    endfunction

    function automatic int store_addr(input int bank, input int x, input int y);
        return bank * MAX_PLANE + ((y * grid_nx + x) % MAX_PLANE);
    endfunction

    // Round half up on the Q.28 sum, floor shift, then clip to 24 bits
    function automatic logic signed [SAMPLE_BITS-1:0] round_q12(input longint acc);
        longint q;
        q = (acc + (longint'(1) <<< (PROD_FRAC - 1))) >>> PROD_FRAC;
        if (q > longint'(SAMPLE_MAX))
            q = longint'(SAMPLE_MAX);
        if (q < longint'(SAMPLE_MIN))
            q = longint'(SAMPLE_MIN);
        return SAMPLE_BITS'(q);
    endfunction

    // One accepted sample: emit the point one plane below if it is interior,
    // then store the sample and step the raster position.
    function automatic void predict_div_curl(input logic signed [SAMPLE_BITS-1:0] fx,
                                             input logic signed [SAMPLE_BITS-1:0] fy,
                                             input logic signed [SAMPLE_BITS-1:0] fz);
        int        cx, cy, cz, here, ob, a_px, a_nx, a_py, a_ny;
        longint    kx, ky, kz;
        longint    dxfx, dxfy, dxfz, dyfx, dyfy, dyfz, dzfx, dzfy, dzfz;
        div_curl_t r;
        cx   = col_at;
        cy   = row_at;
        cz   = plane_at;
        here = store_addr(cz & 1, cx, cy);
        ob   = (cz & 1) ^ 1;
        kx   = longint'(recip_x);
        ky   = longint'(recip_y);
        kz   = longint'(recip_z);

        if (cz >= 2 && cx >= 1 && cx + 2 <= grid_nx && cy >= 1 && cy + 2 <= grid_ny)
        begin
            a_px = store_addr(ob, cx - 1, cy);
            a_nx = store_addr(ob, cx + 1, cy);
            a_py = store_addr(ob, cx, cy - 1);
            a_ny = store_addr(ob, cx, cy + 1);
            dxfx = longint'(plane_fx[a_nx]) - longint'(plane_fx[a_px]);
            dxfy = longint'(plane_fy[a_nx]) - longint'(plane_fy[a_px]);
            dxfz = longint'(plane_fz[a_nx]) - longint'(plane_fz[a_px]);
            dyfx = longint'(plane_fx[a_ny]) - longint'(plane_fx[a_py]);
            dyfy = longint'(plane_fy[a_ny]) - longint'(plane_fy[a_py]);
            dyfz = longint'(plane_fz[a_ny]) - longint'(plane_fz[a_py]);
            dzfx = longint'(fx) - longint'(plane_fx[here]);
            dzfy = longint'(fy) - longint'(plane_fy[here]);
            dzfz = longint'(fz) - longint'(plane_fz[here]);

            r.divergence = round_q12(dxfx * kx + dyfy * ky + dzfz * kz);
            r.curl_x     = round_q12(dyfz * ky - dzfy * kz);
            r.curl_y     = round_q12(dzfx * kz - dxfz * kx);
            r.curl_z     = round_q12(dxfy * kx - dyfx * ky);
            r.pos_x      = RES_BITS'(cx);
            r.pos_y      = RES_BITS'(cy);
            r.pos_z      = RES_BITS'(cz - 1);
            r.last       = (cx + 2 == grid_nx && cy + 2 == grid_ny && cz + 1 == grid_nz);
            div_curl_expected.push_back(r);
        end

        plane_fx[here] = fx;
        plane_fy[here] = fy;
        plane_fz[here] = fz;

        cx++;
        if (cx >= grid_nx)
        begin
            cx = 0;
            cy++;
            if (cy >= grid_ny)
            begin
                cy = 0;
                cz++;
                if (cz >= grid_nz)
                    cz = 0;
            end
        end
        col_at   = cx;
        row_at   = cy;
        plane_at = cz;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void compare_field(input string label,
                                          input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        div_curl_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (div_curl_expected.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: result transfer with none expected, got pos %0d/%0d/%0d",
                             $time, pos_x, pos_y, pos_z);
            end
            else
            begin
                want = div_curl_expected.pop_front();
                compare_field("divergence", want.divergence, divergence);
                compare_field("curl_x", want.curl_x, curl_x);
                compare_field("curl_y", want.curl_y, curl_y);
                compare_field("curl_z", want.curl_z, curl_z);
                compare_field("pos_x", want.pos_x, pos_x);
                compare_field("pos_y", want.pos_y, pos_y);
                compare_field("pos_z", want.pos_z, pos_z);
                compare_field("last", want.last, last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (all entered and left on a rising edge)
    // ------------------------------------------------------------------

    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input sample_mix_t mix);
        sample_mix_t m;
        m = mix;
        if (m == MIX_ANY)
            m = sample_mix_t'($urandom_range(2));
        case (m)
            MIX_SMALL:
                return SAMPLE_BITS'(int'($urandom_range(8191)) - 4096);
            MIX_EXTREME:
                case ($urandom_range(3))
                    0:       return SAMPLE_MAX;
                    1:       return SAMPLE_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            default:
                return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [RECIP_W-1:0] draw_recip();
        case ($urandom_range(7))
            0:       return '0;
            1:       return RECIP_MAX;
            2:       return RECIP_W'($urandom());
            default: return RECIP_W'($urandom_range(131072, 1000));
        endcase
    endfunction

    // Mostly small axes so grids close often; now and then a two-point axis
    // or a long one
    function automatic int draw_res();
        case ($urandom_range(9))
            0:       return 2;
            1:       return $urandom_range(20, 7);
            default: return $urandom_range(6, 3);
        endcase
    endfunction

    // One sample transfer; the model is stepped once the edge has taken it
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] fx,
                               input logic signed [SAMPLE_BITS-1:0] fy,
                               input logic signed [SAMPLE_BITS-1:0] fz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        field_x  <= fx;
        field_y  <= fy;
        field_z  <= fz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_div_curl(fx, fy, fz);
    endtask

    task automatic send_run(input int count, input sample_mix_t mix);
        repeat (count)
            send_sample(draw_sample(mix), draw_sample(mix), draw_sample(mix));
    endtask

    // Hold the input side off until every queued result has been seen, then
    // give trailing non-interior samples time to leave the pipeline
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (div_curl_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_config(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] nx,
                            input logic [CFG_DATA_W-1:0] ny,
                            input logic [CFG_DATA_W-1:0] nz,
                            input logic [RECIP_W-1:0]    kx,
                            input logic [RECIP_W-1:0]    ky,
                            input logic [RECIP_W-1:0]    kz);
        wait_drained();
        cfg_write(REG_RES_X, nx);
        cfg_write(REG_RES_Y, ny);
        cfg_write(REG_RES_Z, nz);
        cfg_write(REG_INV_TWO_DX, CFG_DATA_W'(kx));
        cfg_write(REG_INV_TWO_DY, CFG_DATA_W'(ky));
        cfg_write(REG_INV_TWO_DZ, CFG_DATA_W'(kz));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset shape 10x10x10 and reset scale: three planes give the first
    // layer of interior points; the grid is left open on purpose
    task automatic test_reset_values();
        send_run(3 * RES_AT_RESET * RES_AT_RESET, MIX_ANY);
        wait_drained();
    endtask

    // Full-scale reciprocals with full-swing samples: divergence clips high
    // then low, then a grid of random extremes for the curl terms
    task automatic test_saturation();
        logic signed [SAMPLE_BITS-1:0] hi, lo;
        set_grid(3, 3, 3, RECIP_MAX, RECIP_MAX, RECIP_MAX);
        for (int p = 0; p < 2; p++)
        begin
            hi = p ? SAMPLE_MIN : SAMPLE_MAX;
            lo = p ? SAMPLE_MAX : SAMPLE_MIN;
            for (int z = 0; z < 3; z++)
                for (int y = 0; y < 3; y++)
                    for (int x = 0; x < 3; x++)
                        send_sample(x == 2 ? hi : lo, y == 2 ? hi : lo, z == 2 ? hi : lo);
        end
        send_run(27, MIX_EXTREME);
        wait_drained();
    endtask

    // Out-of-range resolution writes, two-point axes (never a result) and
    // the largest extent on each axis
    task automatic test_resolution_limits();
        set_grid(0, 24'hFFFF83, 1, draw_recip(), draw_recip(), draw_recip());
        send_run(2 * 2 * 3 * 2, MIX_FULL);
        set_grid(3, 2, 3, draw_recip(), draw_recip(), draw_recip());
        send_run(18, MIX_FULL);
        set_grid(3, 3, 2, draw_recip(), draw_recip(), draw_recip());
        send_run(18, MIX_FULL);
        set_grid(127, 3, 3, draw_recip(), draw_recip(), draw_recip());
        send_run(MAX_RES * 9, MIX_ANY);
        set_grid(3, 101, 3, draw_recip(), draw_recip(), draw_recip());
        send_run(MAX_RES * 9, MIX_ANY);
        // low seven bits of 0xE4 give exactly MAX_RES
        set_grid(3, 3, 24'h0000E4, draw_recip(), draw_recip(), draw_recip());
        send_run(MAX_RES * 9, MIX_ANY);
        wait_drained();
    endtask

    // Rewriting a resolution part-way through restarts the raster
    task automatic test_restart_mid_grid();
        set_grid(4, 5, 4, draw_recip(), draw_recip(), draw_recip());
        send_run(47, MIX_ANY);
        wait_drained();
        cfg_write(REG_RES_Y, 5);
        send_run(80, MIX_ANY);
        wait_drained();
    endtask

    // Writes to undecoded indexes must leave the raster alone; the grid then
    // closes and a second one follows straight on
    task automatic test_ignored_index();
        set_grid(4, 4, 5, draw_recip(), draw_recip(), draw_recip());
        send_run(37, MIX_ANY);
        wait_drained();
        cfg_write(REG_SPARE_6, CFG_DATA_W'($urandom()));
        cfg_write(REG_SPARE_7, CFG_DATA_W'($urandom()));
        send_run(80 - 37 + 80, MIX_ANY);
        wait_drained();
    endtask

    // Mostly whole grids with random content, some back to back, some cut
    // short and abandoned by a reconfigure
    task automatic test_random_grids(input int items, input int send_pct, input int recv_pct);
        int  sent, points, cut;
        bit  reconfigure;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent          = 0;
        reconfigure   = 1'b1;
        while (sent < items)
        begin
            if (reconfigure || $urandom_range(2) != 0)
                set_grid(draw_res(), draw_res(), draw_res(),
                         draw_recip(), draw_recip(), draw_recip());
            else if ($urandom_range(3) == 0)
                wait_drained();
            points = grid_nx * grid_ny * grid_nz;
            reconfigure = ($urandom_range(7) == 0);
            if (reconfigure)
            begin
                cut = $urandom_range(points - 1, 1);
                send_run(cut, MIX_ANY);
                sent += cut;
            end
            else
            begin
                send_run(points, MIX_ANY);
                sent += points;
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_RES_X;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        field_x   <= '0;
        field_y   <= '0;
        field_z   <= '0;
        out_ready <= 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 51;
        error_count   = 0;
        reset_model();

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_saturation();
        test_resolution_limits();
        test_restart_mid_grid();
        test_ignored_index();
        test_random_grids(200, 38, 51);
        test_random_grids(200, 51, 38);
        test_random_grids(200, 0, 0);
        wait_drained();

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: covers a hung handshake or a result that never turns up
    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
